/* hdl/cdq_pkg.sv */
// Shared constants, codes and interface structs for the circular deque.
// Used by cdq_ctrl and circular_deque_ring_buffer_top; no dependencies.
package cdq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CAP_W      = $clog2(DEPTH + 1);
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned RES_W      = 3 + 2 * DATA_WIDTH;
  localparam int unsigned OUT_W      = ((RES_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOAD = 1'b1
  } state_e;

  // RAM write and read-address request from the controller
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]      raddr_front;
    logic [IDX_W-1:0]      raddr_rear;
  } mem_req_t;

  // registered outcome of one operation, valid while load is high
  typedef struct packed {
    logic                  load;
    logic                  ok;
    logic                  empty;
    logic                  full;
    logic                  fwd_front;
    logic                  fwd_rear;
    logic [DATA_WIDTH-1:0] fwd_data;
  } resp_t;

endpackage

/* hdl/cdq_ram.sv */
// Generic simple dual-port RAM: one write port, two registered read ports.
// Read data reflects the contents before a same-cycle write. No dependencies.
module cdq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

/* hdl/cdq_ctrl.sv */
// Deque controller: head/tail indices, empty flag, capacity register and
// the accept/load sequencer. Depends on cdq_pkg.
module cdq_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cdq_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cdq_pkg::OP_W-1:0]         in_op_i,
  input  logic [cdq_pkg::DATA_WIDTH-1:0]   in_value_i,
  input  logic                             out_free_i,
  output cdq_pkg::mem_req_t                mem_req_o,
  output cdq_pkg::resp_t                   resp_o
);
  import cdq_pkg::*;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic                 empty_q, empty_d;
  logic [CFG_W-1:0]     cfg_q;
  logic [CAP_W-1:0]     cap;
  logic                 accept;
  logic                 load;
  logic                 ok, full_now, full_after;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic                 ok_q, empty_r_q, full_r_q, fwd_front_q, fwd_rear_q;
  logic [DATA_WIDTH-1:0] val_q;
  op_e                  op;

  function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] i, logic [CAP_W-1:0] c);
    logic [CAP_W:0] nxt;
    nxt = (CAP_W+1)'(i) + (CAP_W+1)'(1);
    return (nxt >= (CAP_W+1)'(c)) ? '0 : IDX_W'(nxt);
  endfunction

  function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] i, logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] top;
    top = c - CAP_W'(1);
    return (i == '0) ? IDX_W'(top) : i - IDX_W'(1);
  endfunction

  // clamp capacity: zero acts as one, above depth acts as depth
  always_comb begin
    if (cfg_q == '0) begin
      cap = CAP_W'(1);
    end else if (32'(cfg_q) > 32'(DEPTH)) begin
      cap = CAP_W'(DEPTH);
    end else begin
      cap = CAP_W'(cfg_q);
    end
  end

  assign op       = op_e'(in_op_i);
  assign accept   = in_valid_i && in_ready_o;
  assign full_now = !empty_q && (head_q == step_up(tail_q, cap));

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    ok      = 1'b0;
    we      = 1'b0;
    waddr   = '0;
    unique case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (empty_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b0;
          ok      = 1'b1;
          we      = 1'b1;
        end else if (!full_now) begin
          ok = 1'b1;
          we = 1'b1;
          if (op == OP_PUSH_FRONT) begin
            head_d = step_down(head_q, cap);
            waddr  = head_d;
          end else begin
            tail_d = step_up(tail_q, cap);
            waddr  = tail_d;
          end
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (!empty_q) begin
          ok = 1'b1;
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else if (op == OP_POP_FRONT) begin
            head_d = step_up(head_q, cap);
          end else begin
            tail_d = step_down(tail_q, cap);
          end
        end
      end
      default: ;
    endcase
    full_after = !empty_d && (head_d == step_up(tail_d, cap));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = out_free_i;
      ST_LOAD: load       = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      cfg_q   <= CFG_W'(DEPTH);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // capacity change drops all entries
        cfg_q   <= cfg_wdata_i;
        head_q  <= '0;
        tail_q  <= '0;
        empty_q <= 1'b1;
      end else if (accept) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        empty_q <= empty_d;
      end
    end
  end

  // result flags and forwarding of the value written in the accept cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q        <= ok;
      empty_r_q   <= empty_d;
      full_r_q    <= full_after;
      fwd_front_q <= we && (waddr == head_d);
      fwd_rear_q  <= we && (waddr == tail_d);
      val_q       <= in_value_i;
    end
  end

  assign mem_req_o = '{
    we:          accept && we,
    waddr:       waddr,
    wdata:       in_value_i,
    raddr_front: head_d,
    raddr_rear:  tail_d
  };

  assign resp_o = '{
    load:      load,
    ok:        ok_q,
    empty:     empty_r_q,
    full:      full_r_q,
    fwd_front: fwd_front_q,
    fwd_rear:  fwd_rear_q,
    fwd_data:  val_q
  };

  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CAP_W+1)'(head_q) < (CAP_W+1)'(cap) && (CAP_W+1)'(tail_q) < (CAP_W+1)'(cap))
    else $error("deque index outside capacity");

  a_empty_indices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0 && tail_q == '0))
    else $error("empty deque with nonzero index");

  a_load_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> resp_o.load && !in_ready_o)
    else $error("accepted beat not followed by load");

endmodule

/* hdl/circular_deque_ring_buffer_top.sv */
// Top level of the circular deque: stream ports, ring RAM and output register.
// Depends on cdq_pkg, cdq_ram and cdq_ctrl.

// Double-ended queue of up to DEPTH (16) 32-bit entries held in a ring RAM.
// Each input beat carries an operation in s_tuser_i (0 push front, 1 push
// rear, 2 pop front, 3 pop rear) and a push value in s_tdata_i; each beat
// yields one output beat with success, empty/full and the front and rear
// values after the operation (all ones when empty). The accept cycle
// updates the indices, writes the RAM and launches both reads, and the
// next cycle moves the registered read data into the output register; with
// the output drained, a new beat is taken once the previous one is loaded.
// Writing cfg_wdata_i (capacity, 0 acts as 1, above 16 acts as 16) empties
// the deque. Reset needs no clearing pass.
module circular_deque_ring_buffer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdq_pkg::CFG_W-1:0]     cfg_wdata_i,    // capacity_in_use
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [cdq_pkg::DATA_WIDTH-1:0] s_tdata_i,     // [31:0] push_value
  input  logic [cdq_pkg::OP_W-1:0]      s_tuser_i,      // [1:0] opcode
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // [0] success, [1] is_empty, [2] is_full, [34:3] front_value,
  // [66:35] rear_value, rest zero
  output logic [cdq_pkg::OUT_W-1:0]     m_tdata_o
);
  import cdq_pkg::*;

  mem_req_t              mem_req;
  resp_t                 resp;
  logic [DATA_WIDTH-1:0] rd_front, rd_rear;
  logic [DATA_WIDTH-1:0] front_val, rear_val;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_data_q;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .in_op_i     (s_tuser_i),
    .in_value_i  (s_tdata_i),
    .out_free_i  (!out_valid_q || m_tready_i),
    .mem_req_o   (mem_req),
    .resp_o      (resp)
  );

  cdq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_req.we),
    .waddr_i   (mem_req.waddr),
    .wdata_i   (mem_req.wdata),
    .raddr_a_i (mem_req.raddr_front),
    .rdata_a_o (rd_front),
    .raddr_b_i (mem_req.raddr_rear),
    .rdata_b_o (rd_rear)
  );

  // RAM returns pre-write data, so take the pushed value where it landed
  always_comb begin
    if (resp.empty) begin
      front_val = '1;
      rear_val  = '1;
    end else begin
      front_val = resp.fwd_front ? resp.fwd_data : rd_front;
      rear_val  = resp.fwd_rear  ? resp.fwd_data : rd_rear;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (resp.load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp.load) begin
      out_data_q <= OUT_W'({rear_val, front_val, resp.full, resp.empty, resp.ok});
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp.load |-> (!out_valid_q || m_tready_i))
    else $error("result loaded over an undelivered beat");

  a_empty_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp.load |-> !(resp.empty && resp.full))
    else $error("deque reported both empty and full");

  a_fwd_only_on_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resp.load && (resp.fwd_front || resp.fwd_rear)) |-> resp.ok)
    else $error("forwarded a value from a failed push");

endmodule
